FILE: hdl/mtep_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mtep_pkg;

  // Result kinds
  localparam logic [2:0] KIND_CHANNEL = 3'd0;
  localparam logic [2:0] KIND_META    = 3'd1;
  localparam logic [2:0] KIND_SYSEX   = 3'd2;
  localparam logic [2:0] KIND_PAYLOAD = 3'd3;
  localparam logic [2:0] KIND_END     = 3'd4;

  // Byte values
  localparam logic [7:0] VLQ_DATA_MASK = 8'h7F;
  localparam logic [7:0] ST_ONE_LO     = 8'hC0;
  localparam logic [7:0] ST_ONE_HI     = 8'hDF;
  localparam logic [7:0] ST_SYSEX      = 8'hF0;
  localparam logic [7:0] ST_SYS_LO     = 8'hF1;
  localparam logic [7:0] ST_SYS_HI     = 8'hFE;
  localparam logic [7:0] ST_META       = 8'hFF;
  localparam logic [7:0] META_TEMPO    = 8'h51;
  localparam logic [7:0] META_EOT      = 8'h2F;

  // Tempo divider
  localparam int unsigned DIV_Q_BITS   = 36;
  localparam int unsigned DIV_D_BITS   = 16;
  localparam int unsigned DIV_CNT_BITS = 6;
  localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(DIV_Q_BITS - 1);
  localparam logic [DIV_Q_BITS-1:0] MULT_FLOOR = 36'd256;
  localparam logic [15:0] TD_RESET = 16'd96;

  // Datapath operations, one per accepted byte
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_DELTA,
    ACT_STATUS,
    ACT_META_TYPE,
    ACT_LENGTH,
    ACT_DATA1,
    ACT_DATA2,
    ACT_SYS_RUN,
    ACT_PAYLOAD
  } act_t;

  typedef struct packed {
    logic       load;
    logic       clear;
    act_t       act;
    logic       emit;
    logic [2:0] kind;
    logic       tempo;
  } dp_cmd_t;

  typedef struct packed {
    logic byte_hi;
    logic byte_ff;
    logic byte_f0;
    logic byte_sys;
    logic rs_ff;
    logic rs_f0;
    logic rs_sys;
    logic rs_one;
    logic len_zero;
    logic meta_eot;
    logic meta_tempo;
    logic rem_last;
    logic div_done;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: hdl/mtep_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle
module mtep_div (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [mtep_pkg::DIV_Q_BITS-1:0]  numer,
  input  wire logic [mtep_pkg::DIV_D_BITS-1:0]  denom,
  output logic                                  done,
  output logic      [mtep_pkg::DIV_Q_BITS-1:0]  quot
);

  logic                                busy;
  logic [mtep_pkg::DIV_CNT_BITS-1:0]   cnt;
  logic [mtep_pkg::DIV_D_BITS-1:0]     rem;
  logic [mtep_pkg::DIV_D_BITS-1:0]     dvs;
  logic [mtep_pkg::DIV_D_BITS:0]       trial;
  logic                                ge;

  // shift in next numerator bit and try the subtract
  assign trial = {rem, quot[mtep_pkg::DIV_Q_BITS-1]};
  assign ge    = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dvs  <= denom;
        quot <= numer;
      end else if (busy) begin
        rem  <= ge ? mtep_pkg::DIV_D_BITS'(trial - {1'b0, dvs})
                   : trial[mtep_pkg::DIV_D_BITS-1:0];
        quot <= {quot[mtep_pkg::DIV_Q_BITS-2:0], ge};
        cnt  <= cnt + 1'b1;
        if (cnt == mtep_pkg::DIV_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/mtep_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

// Parser registers, result registers and tempo rate divider
module mtep_dpath #(
  parameter int LENGTH_BITS = 28,
  parameter int TICK_BITS   = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire mtep_pkg::dp_cmd_t     cmd,
  output mtep_pkg::dp_status_t       sts,
  input  wire logic [7:0]            data_byte,
  input  wire logic                  cfg_we,
  input  wire logic [15:0]           cfg_data,
  output logic      [2:0]            out_kind,
  output logic      [31:0]           abs_tick,
  output logic      [7:0]            status_byte,
  output logic      [7:0]            data_one,
  output logic      [7:0]            data_two,
  output logic      [27:0]           payload_length,
  output logic      [7:0]            payload_byte,
  output logic                       payload_last,
  output logic      [23:0]           tempo_us,
  output logic      [35:0]           rate_multiplier,
  output logic                       tempo_valid
);

  logic [15:0]            time_division;
  logic [LENGTH_BITS-1:0] len_acc;
  logic [TICK_BITS-1:0]   tick_total;
  logic [7:0]             running_status;
  logic [7:0]             first_data;
  logic [7:0]             meta_kind;
  logic [LENGTH_BITS-1:0] pay_rem;
  logic [23:0]            tempo_gather;
  logic [1:0]             pay_idx;

  // values after an optional new-track clear
  logic [LENGTH_BITS-1:0] eff_acc, eff_rem, new_len;
  logic [TICK_BITS-1:0]   eff_tick;
  logic [7:0]             eff_rs;
  logic [23:0]            eff_gather;
  logic [1:0]             eff_idx;

  logic [LENGTH_BITS-1:0] len_acc_next, pay_rem_next;
  logic [TICK_BITS-1:0]   tick_total_next;
  logic [7:0]             running_status_next, first_data_next, meta_kind_next;
  logic [23:0]            tempo_gather_next;
  logic [1:0]             pay_idx_next;

  logic [7:0]             res_d1, res_d2, res_pbyte;
  logic [27:0]            res_plen;
  logic                   res_plast;

  logic                                  div_done;
  logic [mtep_pkg::DIV_Q_BITS-1:0]       div_quot;
  logic [mtep_pkg::DIV_Q_BITS-1:0]       div_numer;
  logic [15:0]                           div_denom;

  assign eff_acc    = cmd.clear ? '0 : len_acc;
  assign eff_rem    = cmd.clear ? '0 : pay_rem;
  assign eff_tick   = cmd.clear ? '0 : tick_total;
  assign eff_rs     = cmd.clear ? '0 : running_status;
  assign eff_gather = cmd.clear ? '0 : tempo_gather;
  assign eff_idx    = cmd.clear ? '0 : pay_idx;

  // seven more bits of a variable-length quantity
  assign new_len = (eff_acc << 7)
                 | LENGTH_BITS'(data_byte & mtep_pkg::VLQ_DATA_MASK);

  // status flags for the controller
  always_comb begin
    sts.byte_hi    = data_byte[7];
    sts.byte_ff    = (data_byte == mtep_pkg::ST_META);
    sts.byte_f0    = (data_byte == mtep_pkg::ST_SYSEX);
    sts.byte_sys   = data_byte inside {[mtep_pkg::ST_SYS_LO : mtep_pkg::ST_SYS_HI]};
    sts.rs_ff      = (eff_rs == mtep_pkg::ST_META);
    sts.rs_f0      = (eff_rs == mtep_pkg::ST_SYSEX);
    sts.rs_sys     = eff_rs inside {[mtep_pkg::ST_SYS_LO : mtep_pkg::ST_SYS_HI]};
    sts.rs_one     = eff_rs inside {[mtep_pkg::ST_ONE_LO : mtep_pkg::ST_ONE_HI]};
    sts.len_zero   = (new_len == '0);
    sts.meta_eot   = (meta_kind == mtep_pkg::META_EOT);
    sts.meta_tempo = (meta_kind == mtep_pkg::META_TEMPO);
    sts.rem_last   = (eff_rem <= LENGTH_BITS'(1));
    sts.div_done   = div_done;
  end

  // next parser state
  always_comb begin
    len_acc_next        = eff_acc;
    pay_rem_next        = eff_rem;
    tick_total_next     = eff_tick;
    running_status_next = eff_rs;
    first_data_next     = first_data;
    meta_kind_next      = meta_kind;
    tempo_gather_next   = eff_gather;
    pay_idx_next        = eff_idx;
    case (cmd.act)
      mtep_pkg::ACT_DELTA, mtep_pkg::ACT_SYS_RUN: begin
        len_acc_next = new_len;
        if (!data_byte[7]) begin
          tick_total_next = eff_tick + TICK_BITS'(new_len);
          len_acc_next    = '0;
        end
      end
      mtep_pkg::ACT_STATUS:    running_status_next = data_byte;
      mtep_pkg::ACT_META_TYPE: meta_kind_next = data_byte;
      mtep_pkg::ACT_DATA1:     first_data_next = data_byte;
      mtep_pkg::ACT_LENGTH: begin
        len_acc_next = new_len;
        if (!data_byte[7]) begin
          len_acc_next      = '0;
          pay_rem_next      = new_len;
          tempo_gather_next = '0;
          pay_idx_next      = '0;
        end
      end
      mtep_pkg::ACT_PAYLOAD: begin
        pay_rem_next = sts.rem_last ? '0 : eff_rem - 1'b1;
        if (eff_idx != 2'd3) begin
          pay_idx_next = eff_idx + 1'b1;
        end
        case (eff_idx)
          2'd0:    tempo_gather_next = eff_gather | {data_byte, 16'h0000};
          2'd1:    tempo_gather_next = eff_gather | {8'h00, data_byte, 8'h00};
          2'd2:    tempo_gather_next = eff_gather | {16'h0000, data_byte};
          default: tempo_gather_next = eff_gather;
        endcase
      end
      default: ;
    endcase
  end

  // result fields
  always_comb begin
    res_d1    = 8'h00;
    res_d2    = 8'h00;
    res_plen  = 28'h0;
    res_pbyte = 8'h00;
    res_plast = 1'b0;
    case (cmd.act)
      mtep_pkg::ACT_DATA1: res_d1 = data_byte;
      mtep_pkg::ACT_DATA2: begin
        res_d1 = first_data;
        res_d2 = data_byte;
      end
      mtep_pkg::ACT_LENGTH: begin
        res_d1   = sts.rs_ff ? meta_kind : 8'h00;
        res_plen = 28'(new_len);
      end
      mtep_pkg::ACT_PAYLOAD: begin
        res_d1    = sts.rs_ff ? meta_kind : 8'h00;
        res_pbyte = data_byte;
        res_plast = sts.rem_last;
      end
      default: ;
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      time_division <= mtep_pkg::TD_RESET;
    end else if (cfg_we) begin
      time_division <= cfg_data;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      len_acc        <= '0;
      pay_rem        <= '0;
      tick_total     <= '0;
      running_status <= '0;
      first_data     <= '0;
      meta_kind      <= '0;
      tempo_gather   <= '0;
      pay_idx        <= '0;
    end else if (cmd.load) begin
      len_acc        <= len_acc_next;
      pay_rem        <= pay_rem_next;
      tick_total     <= tick_total_next;
      running_status <= running_status_next;
      first_data     <= first_data_next;
      meta_kind      <= meta_kind_next;
      tempo_gather   <= tempo_gather_next;
      pay_idx        <= pay_idx_next;
    end
  end

  // result register; the rate field follows later for tempo events
  always_ff @(posedge clk) begin
    if (cmd.load && cmd.emit) begin
      out_kind        <= cmd.kind;
      abs_tick        <= 32'(eff_tick);
      status_byte     <= running_status_next;
      data_one        <= res_d1;
      data_two        <= res_d2;
      payload_length  <= res_plen;
      payload_byte    <= res_pbyte;
      payload_last    <= res_plast;
      tempo_us        <= cmd.tempo ? tempo_gather_next : 24'h0;
      tempo_valid     <= cmd.tempo;
      rate_multiplier <= mtep_pkg::MULT_FLOOR;
    end else if (div_done) begin
      rate_multiplier <= (div_quot < mtep_pkg::MULT_FLOOR) ? mtep_pkg::MULT_FLOOR : div_quot;
    end
  end

  // tempo * 2560 as two shifted adds; zero division counts as one
  assign div_numer = (36'(tempo_gather_next) << 11) + (36'(tempo_gather_next) << 9);
  assign div_denom = (time_division == 16'h0000) ? 16'h0001 : time_division;

  mtep_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.load & cmd.tempo),
    .numer (div_numer),
    .denom (div_denom),
    .done  (div_done),
    .quot  (div_quot)
  );

endmodule

`default_nettype wire

FILE: hdl/mtep_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

// Parse phase sequencer and handshake control
module mtep_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  new_track,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  input  wire mtep_pkg::dp_status_t  sts,
  output mtep_pkg::dp_cmd_t          cmd
);

  typedef enum logic [2:0] {
    PH_DELTA,
    PH_STATUS,
    PH_DATA1,
    PH_DATA2,
    PH_METATYPE,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_ENDED
  } phase_t;

  phase_t phase, phase_next, ph;
  logic   dividing;
  logic   take;

  // hold off requests while a tempo rate is computed or a result is stuck
  assign in_stall = dividing | (out_valid & out_stall);
  assign take     = in_valid & ~in_stall;
  assign ph       = new_track ? PH_DELTA : phase;

  // decode the byte against the current phase
  always_comb begin
    cmd.load   = take;
    cmd.clear  = new_track;
    cmd.act    = mtep_pkg::ACT_NONE;
    cmd.emit   = 1'b0;
    cmd.kind   = mtep_pkg::KIND_CHANNEL;
    cmd.tempo  = 1'b0;
    phase_next = ph;
    case (ph)
      PH_DELTA: begin
        cmd.act    = mtep_pkg::ACT_DELTA;
        phase_next = sts.byte_hi ? PH_DELTA : PH_STATUS;
      end
      PH_STATUS: begin
        if (sts.byte_hi) begin
          cmd.act = mtep_pkg::ACT_STATUS;
          if (sts.byte_ff) begin
            phase_next = PH_METATYPE;
          end else if (sts.byte_f0) begin
            phase_next = PH_LENGTH;
          end else if (sts.byte_sys) begin
            cmd.emit   = 1'b1;
            phase_next = PH_DELTA;
          end else begin
            phase_next = PH_DATA1;
          end
        end else if (sts.rs_ff) begin
          cmd.act    = mtep_pkg::ACT_META_TYPE;
          phase_next = PH_LENGTH;
        end else if (sts.rs_f0) begin
          // running sysex: byte is the first length byte
          cmd.act    = mtep_pkg::ACT_LENGTH;
          phase_next = PH_LENGTH;
          if (!sts.byte_hi) begin
            cmd.emit   = 1'b1;
            cmd.kind   = mtep_pkg::KIND_SYSEX;
            phase_next = sts.len_zero ? PH_DELTA : PH_PAYLOAD;
          end
        end else if (sts.rs_sys) begin
          // running system status: event now, byte opens the next delta
          cmd.act    = mtep_pkg::ACT_SYS_RUN;
          cmd.emit   = 1'b1;
          phase_next = PH_STATUS;
        end else begin
          cmd.act = mtep_pkg::ACT_DATA1;
          if (sts.rs_one) begin
            cmd.emit   = 1'b1;
            phase_next = PH_DELTA;
          end else begin
            phase_next = PH_DATA2;
          end
        end
      end
      PH_DATA1: begin
        cmd.act = mtep_pkg::ACT_DATA1;
        if (sts.rs_one) begin
          cmd.emit   = 1'b1;
          phase_next = PH_DELTA;
        end else begin
          phase_next = PH_DATA2;
        end
      end
      PH_DATA2: begin
        cmd.act    = mtep_pkg::ACT_DATA2;
        cmd.emit   = 1'b1;
        phase_next = PH_DELTA;
      end
      PH_METATYPE: begin
        cmd.act    = mtep_pkg::ACT_META_TYPE;
        phase_next = PH_LENGTH;
      end
      PH_LENGTH: begin
        cmd.act = mtep_pkg::ACT_LENGTH;
        if (!sts.byte_hi) begin
          cmd.emit = 1'b1;
          if (sts.len_zero && sts.rs_ff && sts.meta_eot) begin
            cmd.kind   = mtep_pkg::KIND_END;
            phase_next = PH_ENDED;
          end else begin
            cmd.kind   = sts.rs_ff ? mtep_pkg::KIND_META : mtep_pkg::KIND_SYSEX;
            phase_next = sts.len_zero ? PH_DELTA : PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        cmd.act  = mtep_pkg::ACT_PAYLOAD;
        cmd.emit = 1'b1;
        cmd.kind = mtep_pkg::KIND_PAYLOAD;
        if (sts.rem_last) begin
          phase_next = PH_DELTA;
          if (sts.rs_ff && sts.meta_eot) begin
            cmd.kind   = mtep_pkg::KIND_END;
            phase_next = PH_ENDED;
          end else if (sts.rs_ff && sts.meta_tempo) begin
            cmd.tempo = 1'b1;
          end
        end
      end
      PH_ENDED: ;
      default: phase_next = PH_DELTA;
    endcase
    // running system status re-enters the delta phase with this byte
    if (cmd.act == mtep_pkg::ACT_SYS_RUN) begin
      phase_next = sts.byte_hi ? PH_DELTA : PH_STATUS;
    end
  end

  // phase, result valid and divide wait
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_DELTA;
      out_valid <= 1'b0;
      dividing  <= 1'b0;
    end else begin
      if (take) begin
        phase <= phase_next;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (take && cmd.emit && !cmd.tempo) begin
        out_valid <= 1'b1;
      end
      if (take && cmd.tempo) begin
        dividing <= 1'b1;
      end
      if (sts.div_done) begin
        dividing  <= 1'b0;
        out_valid <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/midi_track_event_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// Track chunk parser: one byte of a MIDI file track per request on the input
// channel (data_byte, new_track); at most one event request on the output.
// Delta times accumulate into abs_tick, running status is honoured, meta and
// sysex events give a header followed by one request per payload byte.
// A byte that completes an event loads the output register at the
// accepting edge, so out_valid rises the next cycle. Bytes that complete no
// event are accepted every cycle while no result is stalled and no divide
// runs. The last byte of a tempo meta starts a serial divider (one quotient
// bit per cycle over 36 bits) for rate_multiplier; out_valid for that request
// rises once the divider is done, and input is stalled meanwhile.
// The input is taken in the same cycle the waiting result leaves; while the
// receiver stalls a valid result, in_stall is held high and nothing changes.
// Reset (rst, synchronous) clears tick, status and phase and sets
// time_division to 96; no results are pending after it. Write time_division
// through cfg_we/cfg_data only while the block is idle.
module midi_track_event_parser #(
  parameter int LENGTH_BITS = 28,
  parameter int TICK_BITS   = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        new_track,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_kind,
  output logic [31:0]      abs_tick,
  output logic [7:0]       status_byte,
  output logic [7:0]       data_one,
  output logic [7:0]       data_two,
  output logic [27:0]      payload_length,
  output logic [7:0]       payload_byte,
  output logic             payload_last,
  output logic [23:0]      tempo_us,
  output logic [35:0]      rate_multiplier,
  output logic             tempo_valid
);

  mtep_pkg::dp_cmd_t    cmd;
  mtep_pkg::dp_status_t sts;

  mtep_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .new_track (new_track),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mtep_dpath #(
    .LENGTH_BITS (LENGTH_BITS),
    .TICK_BITS   (TICK_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .data_byte       (data_byte),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .out_kind        (out_kind),
    .abs_tick        (abs_tick),
    .status_byte     (status_byte),
    .data_one        (data_one),
    .data_two        (data_two),
    .payload_length  (payload_length),
    .payload_byte    (payload_byte),
    .payload_last    (payload_last),
    .tempo_us        (tempo_us),
    .rate_multiplier (rate_multiplier),
    .tempo_valid     (tempo_valid)
  );

endmodule

`default_nettype wire

FILE: tb/sv/midi_track_event_checker.sv
`timescale 1ns / 1ps

module midi_track_event_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        new_track,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_kind,
  input  logic [31:0] abs_tick,
  input  logic [7:0]  status_byte,
  input  logic [7:0]  data_one,
  input  logic [7:0]  data_two,
  input  logic [27:0] payload_length,
  input  logic [7:0]  payload_byte,
  input  logic        payload_last,
  input  logic [23:0] tempo_us,
  input  logic [35:0] rate_multiplier,
  input  logic        tempo_valid,
  output int          fail_count,
  output int          pending_count
);

  typedef enum logic [2:0] {
    SEEK_DELTA,
    SEEK_STATUS,
    SEEK_DATA1,
    SEEK_DATA2,
    SEEK_META_TYPE,
    SEEK_LENGTH,
    IN_PAYLOAD,
    TRACK_DONE
  } parse_phase_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] tick;
    logic [7:0]  status;
    logic [7:0]  d1;
    logic [7:0]  d2;
    logic [27:0] plen;
    logic [7:0]  pbyte;
    logic        plast;
    logic [23:0] tempo;
    logic [35:0] rate;
    logic        tempo_ok;
  } midi_event_t;

  // Shadow of the parser state
  logic [15:0]  tick_divisor = mtep_pkg::TD_RESET;
  parse_phase_t phase = SEEK_DELTA;
  logic [27:0]  vlq_acc = '0;
  logic [31:0]  tick_sum = '0;
  logic [7:0]   run_status = '0;
  logic [7:0]   held_data = '0;
  logic [7:0]   meta_code = '0;
  logic [27:0]  bytes_left = '0;
  logic [23:0]  tempo_acc = '0;
  logic [1:0]   tempo_idx = '0;

  midi_event_t pending_events [$];
  int          mismatches = 0;

  // Event as the block should report it from the current state
  function automatic midi_event_t make_event(input logic [2:0] kind,
                                             input logic [7:0] d1, d2,
                                             input logic [27:0] plen,
                                             input logic [7:0] pbyte,
                                             input logic plast, is_tempo);
    midi_event_t ev;
    logic [63:0] divisor;
    logic [63:0] scaled;
    ev.kind     = kind;
    ev.tick     = tick_sum;
    ev.status   = run_status;
    ev.d1       = d1;
    ev.d2       = d2;
    ev.plen     = plen;
    ev.pbyte    = pbyte;
    ev.plast    = plast;
    ev.tempo_ok = is_tempo;
    ev.tempo    = is_tempo ? tempo_acc : 24'd0;
    scaled      = 64'(mtep_pkg::MULT_FLOOR);
    if (is_tempo) begin
      // tempo * 10 in Q.8, divisor of zero behaves as one
      divisor = (tick_divisor == 16'd0) ? 64'd1 : {48'd0, tick_divisor};
      scaled  = ({40'd0, tempo_acc} * 64'd2560) / divisor;
      if (scaled < 64'(mtep_pkg::MULT_FLOOR)) scaled = 64'(mtep_pkg::MULT_FLOOR);
    end
    ev.rate = scaled[35:0];
    return ev;
  endfunction

  // One byte of a delta time; high bits fall off the 28-bit accumulator
  task automatic take_delta(input logic [7:0] b);
    vlq_acc = {vlq_acc[20:0], b[6:0]};
    if (!b[7]) begin
      tick_sum = tick_sum + {4'd0, vlq_acc};
      vlq_acc  = '0;
      phase    = SEEK_STATUS;
    end
  endtask

  // One byte of a meta or sysex length; header goes out once complete
  task automatic take_length(input logic [7:0] b);
    logic        is_meta;
    logic [27:0] len;
    is_meta = (run_status == mtep_pkg::ST_META);
    vlq_acc = {vlq_acc[20:0], b[6:0]};
    if (!b[7]) begin
      len        = vlq_acc;
      vlq_acc    = '0;
      bytes_left = len;
      tempo_acc  = '0;
      tempo_idx  = '0;
      if (len == 28'd0 && is_meta && meta_code == mtep_pkg::META_EOT) begin
        pending_events.push_back(make_event(mtep_pkg::KIND_END, meta_code, 8'd0, 28'd0,
                                            8'd0, 1'b0, 1'b0));
        phase = TRACK_DONE;
      end else begin
        pending_events.push_back(make_event(is_meta ? mtep_pkg::KIND_META
                                                    : mtep_pkg::KIND_SYSEX,
                                            is_meta ? meta_code : 8'd0, 8'd0, len,
                                            8'd0, 1'b0, 1'b0));
        phase = (len == 28'd0) ? SEEK_DELTA : IN_PAYLOAD;
      end
    end
  endtask

  // First data byte of a channel event
  task automatic take_data1(input logic [7:0] b);
    held_data = b;
    if (run_status inside {[mtep_pkg::ST_ONE_LO : mtep_pkg::ST_ONE_HI]}) begin
      pending_events.push_back(make_event(mtep_pkg::KIND_CHANNEL, b, 8'd0, 28'd0, 8'd0,
                                          1'b0, 1'b0));
      phase = SEEK_DELTA;
    end else begin
      phase = SEEK_DATA2;
    end
  endtask

  task automatic parse_track_byte(input logic [7:0] b, input logic nt);
    logic is_meta;
    logic last;
    if (nt) begin
      tick_sum   = '0;
      run_status = '0;
      phase      = SEEK_DELTA;
      vlq_acc    = '0;
      bytes_left = '0;
      tempo_idx  = '0;
      tempo_acc  = '0;
    end
    case (phase)
      SEEK_DELTA: take_delta(b);
      SEEK_STATUS: begin
        if (b[7]) begin
          run_status = b;
          if (b == mtep_pkg::ST_META) begin
            phase = SEEK_META_TYPE;
          end else if (b == mtep_pkg::ST_SYSEX) begin
            phase = SEEK_LENGTH;
          end else if (b >= mtep_pkg::ST_SYS_LO) begin
            pending_events.push_back(make_event(mtep_pkg::KIND_CHANNEL, 8'd0, 8'd0,
                                                28'd0, 8'd0, 1'b0, 1'b0));
            phase = SEEK_DELTA;
          end else begin
            phase = SEEK_DATA1;
          end
        end else if (run_status == mtep_pkg::ST_META) begin
          // running meta: the byte is the meta type
          meta_code = b;
          phase     = SEEK_LENGTH;
        end else if (run_status == mtep_pkg::ST_SYSEX) begin
          // running sysex: the byte opens the length
          phase = SEEK_LENGTH;
          take_length(b);
        end else if (run_status >= mtep_pkg::ST_SYS_LO) begin
          // running system status: event, then the byte starts the next delta
          pending_events.push_back(make_event(mtep_pkg::KIND_CHANNEL, 8'd0, 8'd0,
                                              28'd0, 8'd0, 1'b0, 1'b0));
          phase = SEEK_DELTA;
          take_delta(b);
        end else begin
          take_data1(b);
        end
      end
      SEEK_DATA1: take_data1(b);
      SEEK_DATA2: begin
        pending_events.push_back(make_event(mtep_pkg::KIND_CHANNEL, held_data, b, 28'd0,
                                            8'd0, 1'b0, 1'b0));
        phase = SEEK_DELTA;
      end
      SEEK_META_TYPE: begin
        meta_code = b;
        phase     = SEEK_LENGTH;
      end
      SEEK_LENGTH: take_length(b);
      IN_PAYLOAD: begin
        is_meta = (run_status == mtep_pkg::ST_META);
        last    = (bytes_left <= 28'd1);
        // first three payload bytes form the tempo, MSB first
        if (tempo_idx != 2'd3) begin
          case (tempo_idx)
            2'd0:    tempo_acc[23:16] = b;
            2'd1:    tempo_acc[15:8]  = b;
            default: tempo_acc[7:0]   = b;
          endcase
          tempo_idx = tempo_idx + 2'd1;
        end
        bytes_left = last ? 28'd0 : bytes_left - 28'd1;
        if (last && is_meta && meta_code == mtep_pkg::META_EOT) begin
          pending_events.push_back(make_event(mtep_pkg::KIND_END, meta_code, 8'd0,
                                              28'd0, b, 1'b1, 1'b0));
          phase = TRACK_DONE;
        end else begin
          pending_events.push_back(make_event(mtep_pkg::KIND_PAYLOAD,
                                              is_meta ? meta_code : 8'd0,
                                              8'd0, 28'd0, b, last,
                                              last && is_meta &&
                                              meta_code == mtep_pkg::META_TEMPO));
          if (last) phase = SEEK_DELTA;
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string label, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected %0h got %0h", $time, label, want_v, got_v);
      mismatches++;
    end
  endtask

  // Follow both channels and the register port
  always @(posedge clk) begin
    midi_event_t want;
    if (rst) begin
      tick_divisor = mtep_pkg::TD_RESET;
      phase      = SEEK_DELTA;
      vlq_acc    = '0;
      tick_sum   = '0;
      run_status = '0;
      held_data  = '0;
      meta_code  = '0;
      bytes_left = '0;
      tempo_acc  = '0;
      tempo_idx  = '0;
      pending_events.delete();
    end else begin
      if (cfg_we) tick_divisor = cfg_data;
      if (in_valid && !in_stall) parse_track_byte(data_byte, new_track);
      if (out_valid && !out_stall) begin
        if (pending_events.size() == 0) begin
          $display("%0t: expected no result request, got kind %0d tick %0h", $time,
                   out_kind, abs_tick);
          mismatches++;
        end else begin
          want = pending_events.pop_front();
          check_field("out_kind", 64'(want.kind), 64'(out_kind));
          check_field("abs_tick", 64'(want.tick), 64'(abs_tick));
          check_field("status_byte", 64'(want.status), 64'(status_byte));
          check_field("data_one", 64'(want.d1), 64'(data_one));
          check_field("data_two", 64'(want.d2), 64'(data_two));
          check_field("payload_length", 64'(want.plen), 64'(payload_length));
          check_field("payload_byte", 64'(want.pbyte), 64'(payload_byte));
          check_field("payload_last", 64'(want.plast), 64'(payload_last));
          check_field("tempo_us", 64'(want.tempo), 64'(tempo_us));
          check_field("rate_multiplier", 64'(want.rate), 64'(rate_multiplier));
          check_field("tempo_valid", 64'(want.tempo_ok), 64'(tempo_valid));
        end
      end
    end
    fail_count    <= mismatches;
    pending_count <= pending_events.size();
  end

endmodule

FILE: tb/sv/tb_midi_track_event_parser.sv
`timescale 1ns / 1ps

module tb_midi_track_event_parser;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 50;
  localparam int PHASE_BYTES   = 170;
  localparam int NUM_PHASES    = 6;

  // Opening track: running status after reset, delta overflow, empty sysex,
  // running sysex, system status explicit and running, short tempo,
  // running meta end of track, then a byte that must be ignored
  localparam logic [7:0] OPENING [25] = '{
    8'h00, 8'h40, 8'h41,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hF0, 8'h00,
    8'h00, 8'h00,
    8'h00, 8'hF6,
    8'h00, 8'h7F,
    8'hFF, 8'h51, 8'h02, 8'h12, 8'h34,
    8'h00, 8'h2F, 8'h00,
    8'h90
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_data = 16'd0;
  logic        in_valid = 1'b0;
  logic [7:0]  data_byte = 8'd0;
  logic        new_track = 1'b0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [2:0]  out_kind;
  logic [31:0] abs_tick;
  logic [7:0]  status_byte;
  logic [7:0]  data_one;
  logic [7:0]  data_two;
  logic [27:0] payload_length;
  logic [7:0]  payload_byte;
  logic        payload_last;
  logic [23:0] tempo_us;
  logic [35:0] rate_multiplier;
  logic        tempo_valid;
  int          fail_count;
  int          pending_count;

  logic        calm = 1'b0;
  int          idle_cycles = 0;
  int          stall_left = 0;
  int          bytes_sent = 0;
  logic [7:0]  cur_status = 8'd0;
  logic        skip_delta = 1'b0;
  logic        restart = 1'b0;

  midi_track_event_parser u_top (.*);

  midi_track_event_checker u_check (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver stall: runs of ready with short stalls, now and then a long one
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (calm || out_stall) begin
      out_stall  <= 1'b0;
      stall_left <= $urandom_range(0, calm ? 30 : 12);
    end else begin
      out_stall  <= 1'b1;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                : $urandom_range(0, 2);
    end
  end

  // Watchdog on cycles with no request moving
  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, IDLE_LIMIT);
      $display("** midi_track_event_parser: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_junk();
    return ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, 3)) : 0;
  endfunction

  function automatic logic [7:0] pick_meta_code();
    logic [7:0] t;
    t = 8'($urandom_range(0, 127));
    if ($urandom_range(0, 99) < 45 || t == mtep_pkg::META_EOT) t = mtep_pkg::META_TEMPO;
    return t;
  endfunction

  // One byte request, with a random gap in front unless calm
  task automatic put(input logic [7:0] b, input logic nt);
    int gap;
    int r;
    gap = 0;
    if (!calm) begin
      r = $urandom_range(0, 99);
      if (r >= 90) gap = $urandom_range(8, 40);
      else if (r >= 55) gap = $urandom_range(1, 3);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    new_track <= nt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Variable-length number; junk leading groups are shifted out of 28 bits
  task automatic put_vlq(input logic [27:0] v, input int junk, input logic nt);
    int   groups;
    logic first;
    groups = 1;
    while (groups < 4 && (v >> (7 * groups)) != 0) groups++;
    if (junk > 0) groups = 4;
    first = nt;
    for (int i = 0; i < junk; i++) begin
      put(8'h80 | 8'($urandom_range(0, 127)), first);
      first = 1'b0;
    end
    for (int g = groups - 1; g >= 0; g--) begin
      put({g != 0, 7'(v >> (7 * g))}, first);
      first = 1'b0;
    end
  endtask

  // Length then payload; fill < 0 gives random payload bytes
  task automatic put_body(input int len, input int junk, input int fill);
    put_vlq(28'(len), junk, 1'b0);
    for (int i = 0; i < len; i++)
      put((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill), 1'b0);
  endtask

  task automatic put_meta(input logic [7:0] mt);
    int len;
    int fill;
    int r;
    put(mt, 1'b0);
    r    = $urandom_range(0, 99);
    fill = -1;
    if (mt == mtep_pkg::META_TEMPO) begin
      len = (r < 70) ? 3 : $urandom_range(0, 5);
      r   = $urandom_range(0, 99);
      if (r < 15) fill = 0;
      else if (r < 30) fill = 255;
    end else begin
      len = $urandom_range(0, 6);
    end
    put_body(len, pick_junk(), fill);
    if (mt == mtep_pkg::META_EOT) restart = 1'b1;
  endtask

  // Data bytes of a channel event; under running status the first stays below 80h
  task automatic put_data(input logic [7:0] st, input logic running);
    put((!running && $urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(0, 127)), 1'b0);
    if (!(st inside {[mtep_pkg::ST_ONE_LO : mtep_pkg::ST_ONE_HI]}))
      put(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                      : 8'($urandom_range(0, 127)), 1'b0);
  endtask

  // One track event: delta time, then a mix of well-formed and broken bodies
  task automatic put_event();
    int          r;
    logic        nt;
    logic [7:0]  st;
    logic [27:0] delta;
    if ($urandom_range(0, 19) == 0) calm <= ~calm;
    nt = restart || ($urandom_range(0, 59) == 0);
    if (nt || !skip_delta) begin
      r = $urandom_range(0, 99);
      if (r < 55) delta = 28'($urandom_range(0, 127));
      else if (r < 80) delta = 28'($urandom_range(128, 16383));
      else if (r < 95) delta = 28'($urandom);
      else delta = 28'hFFFFFFF;
      put_vlq(delta, pick_junk(), nt);
      if (nt) cur_status = 8'd0;
    end
    skip_delta = 1'b0;
    restart    = 1'b0;

    r = $urandom_range(0, 99);
    if (r < 30) begin
      // channel event with explicit status
      st = 8'($urandom_range(8'h80, 8'hEF));
      put(st, 1'b0);
      cur_status = st;
      put_data(st, 1'b0);
    end else if (r < 52) begin
      // running status, whatever is in force
      if (cur_status == mtep_pkg::ST_META) begin
        put_meta(($urandom_range(0, 1) == 0) ? mtep_pkg::META_TEMPO
                                             : 8'($urandom_range(0, 127)));
      end else if (cur_status == mtep_pkg::ST_SYSEX) begin
        put_body($urandom_range(0, 6), 0, -1);
      end else if (cur_status >= mtep_pkg::ST_SYS_LO) begin
        // this byte also serves as the next delta time
        put(8'($urandom_range(0, 127)), 1'b0);
        skip_delta = 1'b1;
      end else begin
        put_data(cur_status, 1'b1);
      end
    end else if (r < 58) begin
      st = 8'($urandom_range(mtep_pkg::ST_SYS_LO, mtep_pkg::ST_SYS_HI));
      put(st, 1'b0);
      cur_status = st;
    end else if (r < 80) begin
      put(mtep_pkg::ST_META, 1'b0);
      cur_status = mtep_pkg::ST_META;
      put_meta(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : pick_meta_code());
    end else if (r < 90) begin
      put(mtep_pkg::ST_SYSEX, 1'b0);
      cur_status = mtep_pkg::ST_SYSEX;
      put_body($urandom_range(0, 6), pick_junk(), -1);
    end else if (r < 94) begin
      // end of track, trailing bytes are dropped until a new track
      put(mtep_pkg::ST_META, 1'b0);
      put(mtep_pkg::META_EOT, 1'b0);
      put_body(($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0, pick_junk(), -1);
      repeat ($urandom_range(0, 3)) put(8'($urandom_range(0, 255)), 1'b0);
      restart = 1'b1;
    end else if (r < 95) begin
      // near-maximum payload length, abandoned by a new track
      put(mtep_pkg::ST_META, 1'b0);
      put(8'($urandom_range(0, 127)), 1'b0);
      put_vlq(28'hFFFFFFF - 28'($urandom_range(0, 255)), 0, 1'b0);
      repeat ($urandom_range(1, 3)) put(8'($urandom_range(0, 255)), 1'b0);
      restart = 1'b1;
    end else begin
      repeat ($urandom_range(1, 3)) put(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // Wait until every expected result has arrived and the divider is quiet
  task automatic drain();
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int target;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 0) begin
        for (int i = 0; i < 25; i++) put(OPENING[i], i == 0);
        restart = 1'b1;
      end else begin
        drain();
        case (ph)
          1:       cfg_data <= 16'd1;
          2:       cfg_data <= 16'hFFFF;
          3:       cfg_data <= 16'd0;
          4:       cfg_data <= 16'($urandom_range(1, 65535));
          default: cfg_data <= 16'($urandom_range(2, 200));
        endcase
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
      end
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) put_event();
      in_valid <= 1'b0;
    end

    drain();
    if (fail_count == 0) begin
      $display("** midi_track_event_parser: PASSED **");
    end else begin
      $display("** midi_track_event_parser: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/mtep_pkg.sv
hdl/mtep_div.sv
hdl/mtep_dpath.sv
hdl/mtep_ctrl.sv
hdl/midi_track_event_parser.sv
tb/sv/midi_track_event_checker.sv
tb/sv/tb_midi_track_event_parser.sv
